// ----- rtl/core/gcd_lcm_unit_macros.svh -----
// Assertion macros for the gcd_lcm_unit checker.
// No dependencies; include by bare file name.
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GCL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcd_lcm_unit: same-cycle property failed");

// Next-cycle implication.
`define GCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcd_lcm_unit: next-cycle property failed");

`endif

// ----- rtl/core/gcl_pkg.sv -----
// Shared types for the gcd/lcm unit.
// No dependencies.
package gcl_pkg;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GCD  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

endpackage

// ----- rtl/core/gcd_lcm_unit.sv -----
// gcd_lcm_unit: binary gcd, restoring divide a/g, then one multiply by b for the lcm.
// A zero operand goes from idle straight to done, skipping the gcd, divide and multiply.
// Otherwise the gcd loop (with swaps) runs, then the divide, the multiply, then done.
// One transaction at a time; req_tready only while idle, result held until taken.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_tvalid.
// Depends on gcl_pkg; one shared subtractor serves the gcd reduction and the division.
module gcd_lcm_unit #(
   parameter int OPERAND_BITS = 31,
   localparam int REQ_W = ((2 * OPERAND_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((3 * OPERAND_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // operand_a, operand_b, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // divisor, multiple, zero pad
   output logic [0:0]       rsp_tuser    // both_zero
);
   import gcl_pkg::*;

   localparam int N     = OPERAND_BITS;
   localparam int CNT_W = $clog2(N);

   state_type state_ff, state_in;
   logic [N-1:0]     a_ff, a_in, b_ff, b_in;
   logic [N-1:0]     x_ff, x_in, y_ff, y_in, g_ff, g_in;
   logic [2*N-1:0]   prod_ff, prod_in;
   logic             zero_ff, zero_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [N:0]   sub_a, sub_b;
   logic [N+1:0] diff;
   logic         borrow;
   logic [N-1:0] op_a, op_b;

   assign op_a = req_tdata[N-1:0];
   assign op_b = req_tdata[2*N-1:N];

   // shared subtractor
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = {y_ff, x_ff[N-1]};
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, x_ff};
         sub_b = {1'b0, y_ff};
      end
      diff   = {1'b0, sub_a} - {1'b0, sub_b};
      borrow = diff[N+1];
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      g_in     = g_ff;
      prod_in  = prod_ff;
      zero_in  = zero_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_in    = op_a;
               b_in    = op_b;
               x_in    = op_a;
               y_in    = op_b;
               cnt_in  = '0;
               zero_in = (op_a == '0) && (op_b == '0);
               if ((op_a == '0) || (op_b == '0)) begin
                  g_in     = op_a | op_b;
                  prod_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if ((x_ff == '0) || (y_ff == '0)) begin
               g_in     = (x_ff | y_ff) << cnt_ff;
               x_in     = a_ff;
               y_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in   = x_ff >> 1;
               y_in   = y_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (borrow) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               x_in = diff[N:1];
            end
         end
         ST_DIV: begin
            // restoring divide: x shifts dividend out and quotient in, y is remainder
            if (borrow) begin
               y_in = sub_a[N-1:0];
               x_in = {x_ff[N-2:0], 1'b0};
            end else begin
               y_in = diff[N-1:0];
               x_in = {x_ff[N-2:0], 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(N - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = {{N{1'b0}}, x_ff} * {{N{1'b0}}, b_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      g_ff    <= g_in;
      prod_ff <= prod_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = (state_ff == ST_DONE);
   assign rsp_tdata    = RSP_W'({prod_ff, g_ff});
   assign rsp_tuser[0] = zero_ff;

endmodule

// ----- rtl/core/gcd_lcm_unit_chk.sv -----
// Port-level checker for gcd_lcm_unit, bound to each gcd_lcm_unit instance.
// Depends on gcd_lcm_unit_macros.svh.
`include "gcd_lcm_unit_macros.svh"

module gcd_lcm_unit_chk #(
   parameter int OPERAND_BITS = 31,
   localparam int RSP_W = ((3 * OPERAND_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [0:0]       rsp_tuser
);

   // stalled result holds
   `GCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one transaction in flight
   `GCL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `GCL_ASSERT_SAME(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready)
   // both operands zero gives zero results
   `GCL_ASSERT_SAME(a_zero_results, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)

endmodule

bind gcd_lcm_unit gcd_lcm_unit_chk #(.OPERAND_BITS(OPERAND_BITS)) u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- sim/gcd_lcm_checker.sv -----
`timescale 1ns / 100ps
// Checker for gcd_lcm_unit: watches both stream channels, predicts gcd/lcm per transaction
// and compares each result in order. Standalone; no package needed.
module gcd_lcm_checker #(
   parameter int OPERAND_BITS = 31,
   localparam int REQ_W = ((2 * OPERAND_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((3 * OPERAND_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic [0:0]       rsp_tuser,
   output int               failures,
   output int               pending
);

   typedef struct packed {
      logic [OPERAND_BITS-1:0]   divisor;
      logic [2*OPERAND_BITS-1:0] multiple;
      logic                      both_zero;
   } gcd_lcm_result_type;

   gcd_lcm_result_type predicted_results[$];

   function automatic gcd_lcm_result_type predict_gcd_lcm(input logic [OPERAND_BITS-1:0] a,
                                                          input logic [OPERAND_BITS-1:0] b);
      gcd_lcm_result_type res;
      longint unsigned x;
      longint unsigned y;
      longint unsigned r;
      x = a;
      y = b;
      res = '0;
      if (a == 0 && b == 0) begin
         res.both_zero = 1'b1;
      end else begin
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         res.divisor = x[OPERAND_BITS-1:0];
         if (a != 0 && b != 0)
            res.multiple = (2*OPERAND_BITS)'((longint'(a) / x) * longint'(b));
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t %s: got %0h, want %0h", $realtime, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      gcd_lcm_result_type want;
      gcd_lcm_result_type got;
      if (reset) begin
         failures = 0;
         pending = 0;
         predicted_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.divisor   = rsp_tdata[OPERAND_BITS-1:0];
            got.multiple  = rsp_tdata[3*OPERAND_BITS-1:OPERAND_BITS];
            got.both_zero = rsp_tuser[0];
            if (predicted_results.size() == 0) begin
               report_mismatch("unexpected result transaction", 64'(got.divisor), 64'(0));
            end else begin
               want = predicted_results.pop_front();
               if (got.divisor !== want.divisor)
                  report_mismatch("divisor", 64'(got.divisor), 64'(want.divisor));
               if (got.multiple !== want.multiple)
                  report_mismatch("multiple", 64'(got.multiple), 64'(want.multiple));
               if (got.both_zero !== want.both_zero)
                  report_mismatch("both_zero", 64'(got.both_zero), 64'(want.both_zero));
            end
         end
         if (req_tvalid && req_tready)
            predicted_results.push_back(predict_gcd_lcm(req_tdata[OPERAND_BITS-1:0],
                                                        req_tdata[2*OPERAND_BITS-1:OPERAND_BITS]));
         pending = predicted_results.size();
      end
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for gcd_lcm_unit: clock, reset, operand stimulus and result drain.
// Depends on gcd_lcm_unit and gcd_lcm_checker.
module tb_top;

   localparam int OPERAND_BITS = 31;
   localparam int REQ_W = ((2 * OPERAND_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((3 * OPERAND_BITS + 7) / 8) * 8;
   localparam logic [OPERAND_BITS-1:0] OP_MAX = '1;
   localparam int RANDOM_ITEMS = 1580;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 500;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0]       rsp_tuser;
   int               failures;
   int               pending;
   bit               burst;

   gcd_lcm_unit #(.OPERAND_BITS(OPERAND_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   gcd_lcm_checker #(.OPERAND_BITS(OPERAND_BITS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .failures   (failures),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20_000_000;
      $display("gcd_lcm_unit: mismatch");
      $finish;
   end

   // entered at a falling edge, returns at the falling edge after acceptance
   task automatic send_operands(input logic [OPERAND_BITS-1:0] a,
                                input logic [OPERAND_BITS-1:0] b);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= REQ_W'({b, a});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   function automatic logic [OPERAND_BITS-1:0] any_operand();
      return OPERAND_BITS'($urandom());
   endfunction

   task automatic send_random_pair();
      int sel;
      int g;
      logic [OPERAND_BITS-1:0] a;
      logic [OPERAND_BITS-1:0] b;
      sel = $urandom_range(0, 99);
      g = $urandom_range(1, 1 << 15);
      if (sel < 30) begin
         a = any_operand();
         b = any_operand();
      end else if (sel < 55) begin
         a = OPERAND_BITS'(g * $urandom_range(1, 1 << 15));
         b = OPERAND_BITS'(g * $urandom_range(1, 1 << 15));
      end else if (sel < 70) begin
         a = OPERAND_BITS'($urandom_range(0, 20));
         b = OPERAND_BITS'($urandom_range(0, 20));
      end else if (sel < 80) begin
         a = OPERAND_BITS'(1) << $urandom_range(0, OPERAND_BITS - 1);
         b = $urandom_range(0, 1) ? any_operand()
                                  : OPERAND_BITS'(1) << $urandom_range(0, OPERAND_BITS - 1);
      end else if (sel < 88) begin
         a = $urandom_range(0, 3) == 0 ? '0 : any_operand();
         b = '0;
         if ($urandom_range(0, 1)) begin
            b = a;
            a = '0;
         end
      end else if (sel < 95) begin
         a = OPERAND_BITS'(OP_MAX - $urandom_range(0, 3));
         b = $urandom_range(0, 1) ? a : OPERAND_BITS'(OP_MAX - $urandom_range(0, 3));
      end else begin
         b = OPERAND_BITS'(g);
         a = OPERAND_BITS'(g * $urandom_range(1, 1 << 15));
      end
      if ($urandom_range(0, 1))
         send_operands(a, b);
      else
         send_operands(b, a);
   endtask

   // result drain: random stalls, stall-free stretches, and one long hold-off
   initial begin
      int pause;
      int taken;
      taken = 0;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (taken == HOLD_AT)
            pause = HOLD_CYCLES;
         else if (taken % 150 < 30)
            pause = 0;
         else
            pause = $urandom_range(0, 3);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      burst = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_operands('0, '0);
      send_operands('0, 31'd12);
      send_operands(31'd12, '0);
      send_operands(OP_MAX, '0);
      send_operands('0, OP_MAX);
      send_operands(OP_MAX, OP_MAX);
      send_operands(OP_MAX, 31'd1);
      send_operands(31'd1, OP_MAX);
      send_operands(OP_MAX, OPERAND_BITS'(OP_MAX - 1));
      send_operands(31'd1, 31'd1);
      send_operands(31'h4000_0000, 31'h4000_0000);
      send_operands(31'h4000_0000, 31'd1 << 12);
      send_operands(31'd2147483629, 31'd2147483587);
      send_operands(31'd2147483629, 31'd1);
      send_operands(31'd46368, 31'd28657);
      send_operands(31'd1836311903, 31'd1134903170);
      send_operands(31'd48, 31'd18);
      send_operands(31'd18, 31'd48);
      send_operands(31'd1073741823, 31'd3);
      send_operands(31'h2AAA_AAAA, 31'h5555_5555);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         burst = (i % 200) < 40;
         send_random_pair();
         if (i == RANDOM_ITEMS / 2)
            drain_results();
      end
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (140) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("gcd_lcm_unit: match");
      else
         $display("gcd_lcm_unit: mismatch");
      $finish;
   end

endmodule
